@@ sv/fac_pkg.sv @@
// ----------------------------------------------------------------------------
// fac_pkg: shared types and constants of the fall alarm controller
// Payload structs, configuration register map and reset values, and the
// fall reason codes used between the classifier and the alarm engine.
// ----------------------------------------------------------------------------
package fac_pkg;

  // Queue between classifier and alarm engine
  localparam int unsigned FAC_QUEUE_DEPTH = 2;

  // Configuration port
  localparam int unsigned FAC_CFG_IDX_W  = 4;
  localparam int unsigned FAC_CFG_DATA_W = 34;

  localparam logic [FAC_CFG_IDX_W-1:0] CFG_IMPACT_MAG_SQ   = 4'd0;
  localparam logic [FAC_CFG_IDX_W-1:0] CFG_FREEFALL_MAG_SQ = 4'd1;
  localparam logic [FAC_CFG_IDX_W-1:0] CFG_FLIP_LEVEL      = 4'd2;
  localparam logic [FAC_CFG_IDX_W-1:0] CFG_TILT_LEVEL      = 4'd3;
  localparam logic [FAC_CFG_IDX_W-1:0] CFG_ROLL_RATE_LEVEL = 4'd4;
  localparam logic [FAC_CFG_IDX_W-1:0] CFG_CONFIRM_COUNT   = 4'd5;
  localparam logic [FAC_CFG_IDX_W-1:0] CFG_STABLE_MS       = 4'd6;
  localparam logic [FAC_CFG_IDX_W-1:0] CFG_COUNTDOWN_MS    = 4'd7;

  // Register reset values
  localparam logic [33:0]        RST_IMPACT_MAG_SQ   = 34'd9663676416;
  localparam logic [33:0]        RST_FREEFALL_MAG_SQ = 34'd671089;
  localparam logic signed [15:0] RST_FLIP_LEVEL      = -16'sd11468;
  localparam logic [15:0]        RST_TILT_LEVEL      = 16'd13107;
  localparam logic [15:0]        RST_ROLL_RATE_LEVEL = 16'd52400;
  localparam logic [7:0]         RST_CONFIRM_COUNT   = 8'd4;
  localparam logic [15:0]        RST_STABLE_MS       = 16'd50;
  localparam logic [31:0]        RST_COUNTDOWN_MS    = 32'd10000;

  // Indicator toggles once more than this has passed since the last toggle
  localparam logic [31:0] BLINK_INTERVAL_MS = 32'd500;

  // First test that hit on a sample
  typedef enum logic [2:0] {
    REASON_NONE     = 3'd0,
    REASON_IMPACT   = 3'd1,
    REASON_FREEFALL = 3'd2,
    REASON_FLIP     = 3'd3,
    REASON_TILTX    = 3'd4,
    REASON_TILTY    = 3'd5,
    REASON_ROLLX    = 3'd6,
    REASON_ROLLY    = 3'd7
  } fac_reason_e;

  typedef struct packed {
    logic [33:0]        impact_mag_sq;
    logic [33:0]        freefall_mag_sq;
    logic signed [15:0] flip_level;
    logic [15:0]        tilt_level;
    logic [15:0]        roll_rate_level;
    logic [7:0]         confirm_count;
    logic [15:0]        stable_ms;
    logic [31:0]        countdown_ms;
  } fac_cfg_t;

  // Input beat
  typedef struct packed {
    logic [31:0]        time_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic               imu_valid;
    logic               panic_raw;
    logic               cancel_raw;
  } fac_in_t;

  // Result beat
  typedef struct packed {
    logic       alert_active;
    logic       lockdown;
    logic       indicator_on;
    logic       sos_fire;
    logic       notify_raise;
    logic       notify_cancel;
    logic       fall_confirmed;
    logic [2:0] fall_reason;
    logic [7:0] fall_count;
  } fac_out_t;

  // Classified sample handed from classifier to alarm engine
  typedef struct packed {
    logic [31:0] time_ms;
    logic        imu_valid;
    logic        panic_raw;
    logic        cancel_raw;
    fac_reason_e fall_reason;
  } fac_item_t;

  // Absolute value of a 16-bit signed sample, wide enough for -32768
  function automatic logic [16:0] fac_abs16(logic signed [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return v[15] ? 17'(-ext) : ext;
  endfunction

endpackage

@@ sv/fac_front.sv @@
// ----------------------------------------------------------------------------
// fac_front: sample classifier
// Squares and abs values in a first stage; magnitude sum, threshold tests and
// priority pick of the reason in a second; classified samples go to the queue.
// ----------------------------------------------------------------------------
module fac_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  fac_pkg::fac_in_t  in_data_i,
  input  fac_pkg::fac_cfg_t cfg_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output fac_pkg::fac_item_t q_item_o
);
  import fac_pkg::*;

  // stage 1 registers
  logic               s1_valid_q, s1_valid_d;
  logic [30:0]        sq_x_q, sq_y_q, sq_z_q;
  logic [16:0]        abs_ax_q, abs_ay_q, abs_gx_q, abs_gy_q;
  logic signed [15:0] az_q;
  logic [31:0]        time_q;
  logic               imu_valid_q, panic_q, cancel_q;

  logic               accept;
  logic signed [31:0] prod_x, prod_y, prod_z;
  logic [33:0]        mag_sq;
  fac_reason_e        reason;

  assign accept = push_i && !full_o;
  assign full_o = s1_valid_q && q_full_i;

  // squares of the three acceleration axes
  assign prod_x = 32'(in_data_i.accel_x) * 32'(in_data_i.accel_x);
  assign prod_y = 32'(in_data_i.accel_y) * 32'(in_data_i.accel_y);
  assign prod_z = 32'(in_data_i.accel_z) * 32'(in_data_i.accel_z);

  assign s1_valid_d = accept || (s1_valid_q && q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // stage 1 payload, loaded on each accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_x_q      <= prod_x[30:0];
      sq_y_q      <= prod_y[30:0];
      sq_z_q      <= prod_z[30:0];
      abs_ax_q    <= fac_abs16(in_data_i.accel_x);
      abs_ay_q    <= fac_abs16(in_data_i.accel_y);
      abs_gx_q    <= fac_abs16(in_data_i.gyro_x);
      abs_gy_q    <= fac_abs16(in_data_i.gyro_y);
      az_q        <= in_data_i.accel_z;
      time_q      <= in_data_i.time_ms;
      imu_valid_q <= in_data_i.imu_valid;
      panic_q     <= in_data_i.panic_raw;
      cancel_q    <= in_data_i.cancel_raw;
    end
  end

  // stage 2: threshold tests, first hit wins
  assign mag_sq = 34'(sq_x_q) + 34'(sq_y_q) + 34'(sq_z_q);

  always_comb begin
    if (mag_sq > cfg_i.impact_mag_sq) begin
      reason = REASON_IMPACT;
    end else if (mag_sq < cfg_i.freefall_mag_sq) begin
      reason = REASON_FREEFALL;
    end else if (az_q < cfg_i.flip_level) begin
      reason = REASON_FLIP;
    end else if (abs_ax_q > 17'(cfg_i.tilt_level)) begin
      reason = REASON_TILTX;
    end else if (abs_ay_q > 17'(cfg_i.tilt_level)) begin
      reason = REASON_TILTY;
    end else if (abs_gx_q > 17'(cfg_i.roll_rate_level)) begin
      reason = REASON_ROLLX;
    end else if (abs_gy_q > 17'(cfg_i.roll_rate_level)) begin
      reason = REASON_ROLLY;
    end else begin
      reason = REASON_NONE;
    end
  end

  assign q_push_o             = s1_valid_q && !q_full_i;
  assign q_item_o.time_ms     = time_q;
  assign q_item_o.imu_valid   = imu_valid_q;
  assign q_item_o.panic_raw   = panic_q;
  assign q_item_o.cancel_raw  = cancel_q;
  assign q_item_o.fall_reason = imu_valid_q ? reason : REASON_NONE;

endmodule

@@ sv/fac_queue.sv @@
// ----------------------------------------------------------------------------
// fac_queue: classified sample queue
// Small circular buffer that decouples the classifier from the alarm engine.
// ----------------------------------------------------------------------------
module fac_queue #(
  parameter int unsigned Depth = fac_pkg::FAC_QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fac_pkg::fac_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output fac_pkg::fac_item_t item_o
);
  import fac_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  DepthCnt = CntW'(Depth);

  fac_item_t        mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ sv/fac_back.sv @@
// ----------------------------------------------------------------------------
// fac_back: alarm engine
// Button debounce, consecutive flag counter, alert countdown, SOS lockdown and
// indicator blink; one classified sample per cycle while results are popped.
// ----------------------------------------------------------------------------
module fac_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fac_pkg::fac_cfg_t  cfg_i,
  input  logic               q_valid_i,
  input  fac_pkg::fac_item_t q_item_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output fac_pkg::fac_out_t  out_data_o
);
  import fac_pkg::*;

  logic [7:0]  flag_run_q, flag_run_d;
  logic        panic_last_q, panic_last_d, cancel_last_q, cancel_last_d;
  logic [31:0] panic_since_q, panic_since_d, cancel_since_q, cancel_since_d;
  logic        alert_on_q, alert_on_d;
  logic [31:0] alert_start_q, alert_start_d, blink_q, blink_d;
  logic        ind_q, ind_d, locked_q, locked_d;
  logic        out_valid_q, out_valid_d;
  fac_out_t    out_q, res;

  logic        take, panic_chg, cancel_chg, panic, cancel, confirmed, raise;
  logic        alert_mid, ind_mid, expired;
  logic [31:0] now, panic_age, cancel_age, alert_age, blink_age;

  // a new sample is taken whenever the result register is free or draining
  assign take    = q_valid_i && (!out_valid_q || pop_i);
  assign q_pop_o = take;
  assign empty_o = !out_valid_q;

  assign now        = q_item_i.time_ms;
  assign panic_age  = now - panic_since_q;
  assign cancel_age = now - cancel_since_q;
  assign alert_age  = now - alert_start_q;
  assign blink_age  = now - blink_q;

  // debounce: a level change restarts the stable time at zero
  assign panic_chg  = q_item_i.panic_raw != panic_last_q;
  assign cancel_chg = q_item_i.cancel_raw != cancel_last_q;
  assign panic      = q_item_i.panic_raw && !panic_chg &&
                      (panic_age > 32'(cfg_i.stable_ms));
  assign cancel     = q_item_i.cancel_raw && !cancel_chg &&
                      (cancel_age > 32'(cfg_i.stable_ms));

  // next state and result for the sample at the queue head
  always_comb begin
    flag_run_d     = flag_run_q;
    panic_last_d   = panic_last_q;
    panic_since_d  = panic_since_q;
    cancel_last_d  = cancel_last_q;
    cancel_since_d = cancel_since_q;
    alert_on_d     = alert_on_q;
    alert_start_d  = alert_start_q;
    blink_d        = blink_q;
    ind_d          = ind_q;
    locked_d       = locked_q;
    confirmed      = 1'b0;
    raise          = 1'b0;
    alert_mid      = 1'b0;
    ind_mid        = 1'b0;
    expired        = 1'b0;
    res            = '0;

    if (locked_q) begin
      // lockdown: samples ignored, indicator held on
      ind_d              = 1'b1;
      res.lockdown       = 1'b1;
      res.indicator_on   = 1'b1;
      res.fall_count     = flag_run_q;
    end else begin
      if (panic_chg) begin
        panic_last_d  = q_item_i.panic_raw;
        panic_since_d = now;
      end
      if (cancel_chg) begin
        cancel_last_d  = q_item_i.cancel_raw;
        cancel_since_d = now;
      end

      // consecutive flag counter, saturating
      if (q_item_i.imu_valid) begin
        if (q_item_i.fall_reason != REASON_NONE) begin
          flag_run_d = (flag_run_q == 8'hFF) ? flag_run_q : flag_run_q + 8'd1;
        end else begin
          flag_run_d = '0;
        end
        confirmed = flag_run_d >= cfg_i.confirm_count;
      end

      // alert raise; countdown age is zero on the raising beat
      raise     = (panic || confirmed) && !alert_on_q;
      alert_mid = alert_on_q || raise;
      ind_mid   = raise ? 1'b1 : ind_q;
      expired   = raise ? (cfg_i.countdown_ms == '0)
                        : (alert_age >= cfg_i.countdown_ms);
      if (raise) begin
        alert_on_d    = 1'b1;
        alert_start_d = now;
        ind_d         = 1'b1;
      end

      if (alert_mid) begin
        if (cancel) begin
          alert_on_d        = 1'b0;
          ind_d             = 1'b0;
          res.notify_cancel = 1'b1;
        end else if (expired) begin
          alert_on_d   = 1'b0;
          ind_d        = 1'b0;
          locked_d     = 1'b1;
          res.sos_fire = 1'b1;
        end else if (blink_age > BLINK_INTERVAL_MS) begin
          blink_d = now;
          ind_d   = !ind_mid;
        end
      end

      res.alert_active   = alert_on_d;
      res.lockdown       = locked_d;
      res.indicator_on   = ind_d;
      res.notify_raise   = raise;
      res.fall_confirmed = confirmed;
      res.fall_reason    = q_item_i.fall_reason;
      res.fall_count     = flag_run_d;
    end
  end

  assign out_valid_d = take || (out_valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_run_q     <= '0;
      panic_last_q   <= 1'b1;
      panic_since_q  <= '0;
      cancel_last_q  <= 1'b1;
      cancel_since_q <= '0;
      alert_on_q     <= 1'b0;
      alert_start_q  <= '0;
      blink_q        <= '0;
      ind_q          <= 1'b0;
      locked_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        flag_run_q     <= flag_run_d;
        panic_last_q   <= panic_last_d;
        panic_since_q  <= panic_since_d;
        cancel_last_q  <= cancel_last_d;
        cancel_since_q <= cancel_since_d;
        alert_on_q     <= alert_on_d;
        alert_start_q  <= alert_start_d;
        blink_q        <= blink_d;
        ind_q          <= ind_d;
        locked_q       <= locked_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ sv/fall_alarm_controller.sv @@
// ----------------------------------------------------------------------------
// fall_alarm_controller: IMU fall detector with panic/cancel alert countdown
// Path: each sample passes the classifier register, the queue and the result register.
// Throughput: one sample per cycle while results are popped and nothing stalls; set by the alarm engine step.
// Reset: configuration returns to default values, alert and lockdown clear.
// Classifier, queue and result register are emptied by reset.
// ----------------------------------------------------------------------------
module fall_alarm_controller #(
  parameter int unsigned QueueDepth = fac_pkg::FAC_QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample input
  input  logic                                push,
  output logic                                full,
  input  fac_pkg::fac_in_t                    in_data_i,
  // result output
  output logic                                empty,
  input  logic                                pop,
  output fac_pkg::fac_out_t                   out_data_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fac_pkg::FAC_CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fac_pkg::FAC_CFG_DATA_W-1:0] cfg_data_i
);
  import fac_pkg::*;

  fac_cfg_t  cfg_q;
  fac_item_t fq_item, bq_item;
  logic      fq_push, fq_full, bq_valid, bq_pop;
  logic      cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.impact_mag_sq   <= RST_IMPACT_MAG_SQ;
      cfg_q.freefall_mag_sq <= RST_FREEFALL_MAG_SQ;
      cfg_q.flip_level      <= RST_FLIP_LEVEL;
      cfg_q.tilt_level      <= RST_TILT_LEVEL;
      cfg_q.roll_rate_level <= RST_ROLL_RATE_LEVEL;
      cfg_q.confirm_count   <= RST_CONFIRM_COUNT;
      cfg_q.stable_ms       <= RST_STABLE_MS;
      cfg_q.countdown_ms    <= RST_COUNTDOWN_MS;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_IMPACT_MAG_SQ:   cfg_q.impact_mag_sq   <= cfg_data_i[33:0];
        CFG_FREEFALL_MAG_SQ: cfg_q.freefall_mag_sq <= cfg_data_i[33:0];
        CFG_FLIP_LEVEL:      cfg_q.flip_level      <= $signed(cfg_data_i[15:0]);
        CFG_TILT_LEVEL:      cfg_q.tilt_level      <= cfg_data_i[15:0];
        CFG_ROLL_RATE_LEVEL: cfg_q.roll_rate_level <= cfg_data_i[15:0];
        CFG_CONFIRM_COUNT:   cfg_q.confirm_count   <= cfg_data_i[7:0];
        CFG_STABLE_MS:       cfg_q.stable_ms       <= cfg_data_i[15:0];
        CFG_COUNTDOWN_MS:    cfg_q.countdown_ms    <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // classifier
  fac_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .q_full_i  (fq_full),
    .q_push_o  (fq_push),
    .q_item_o  (fq_item)
  );

  // decoupling queue
  fac_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .item_i  (fq_item),
    .full_o  (fq_full),
    .pop_i   (bq_pop),
    .valid_o (bq_valid),
    .item_o  (bq_item)
  );

  // alarm engine
  fac_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (bq_valid),
    .q_item_i   (bq_item),
    .q_pop_o    (bq_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_data_o (out_data_o)
  );

endmodule
